[rtl/gcrt_pkg.sv]
// Package for the grid cell reservation table.
// Holds the beat types, table entry type, opcodes and default sizes.
// No dependencies.
package gcrt_pkg;

    localparam int DEF_GRID_ROWS  = 16;
    localparam int DEF_GRID_COLS  = 16;
    localparam int DEF_MAX_ROBOTS = 16;

    localparam int ROBOT_W = 4;
    localparam int COORD_W = 4;
    localparam int COUNT_W = 9;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_LOCATE  = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [ROBOT_W-1:0] robot_id;
        logic [COORD_W-1:0] cell_row;
        logic [COORD_W-1:0] cell_col;
    } t_in;

    typedef struct packed {
        logic               granted;
        logic [COUNT_W-1:0] released_count;
    } t_out;

    typedef struct packed {
        logic               held;
        logic [ROBOT_W-1:0] owner;
    } t_entry;

    // Verdict of the compare unit on one table entry
    typedef struct packed {
        logic mine;
        logic release_it;
    } t_unit_res;

endpackage

[rtl/gcrt_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module gcrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/gcrt_unit.sv]
// Shared compare unit: judges one table entry against the current robot
// and its reported cell. Depends on gcrt_pkg.
module gcrt_unit #(
    parameter int ADDR_W = 8
) (
    input  gcrt_pkg::t_entry                i_entry,
    input  logic [gcrt_pkg::ROBOT_W-1:0]    i_robot,
    input  logic [ADDR_W-1:0]               i_idx,
    input  logic [ADDR_W-1:0]               i_here,
    input  logic                            i_here_ok,
    output gcrt_pkg::t_unit_res             o_res
);

    logic w_mine;
    logic w_on_cell;

    assign w_mine    = i_entry.held && (i_entry.owner == i_robot);
    assign w_on_cell = i_here_ok && (i_idx == i_here);

    assign o_res.mine       = w_mine;
    assign o_res.release_it = w_mine && !w_on_cell;

endmodule

[rtl/grid_cell_reservation_table_top.sv]
// Top level of the grid cell reservation table: sequencer, table RAM and
// compare unit. Depends on gcrt_pkg, gcrt_ram and gcrt_unit.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in) takes one beat per item:
//   a cell request or a location report. Output channel (o_out_valid /
//   i_out_ready / o_out) returns exactly one result beat per item.
//   The block works on one item at a time; o_in_ready is high only while
//   no item is in progress.
//   Request: from accept to result the steps are address capture, table
//   read, evaluate and write, and result load.
//   Location report: every table entry is swept; the compare unit checks
//   one table entry per cycle, limited by the single RAM read port.
//   Items with a robot out of range or an off-grid request skip the table
//   and go straight to the result load.
//   Reset: the table is cleared one entry per cycle, with o_in_ready
//   low until every entry is cleared.
//   Receiver stall: a finished result waits in the output register while the
//   block takes and works the next item; that item then holds in its final
//   state, with o_in_ready low, until the waiting beat drains.
module grid_cell_reservation_table_top #(
    parameter int GRID_ROWS  = gcrt_pkg::DEF_GRID_ROWS,
    parameter int GRID_COLS  = gcrt_pkg::DEF_GRID_COLS,
    parameter int MAX_ROBOTS = gcrt_pkg::DEF_MAX_ROBOTS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  gcrt_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output gcrt_pkg::t_out o_out
);

    localparam int DEPTH   = GRID_ROWS * GRID_COLS;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int HW      = ADDR_W + 8;
    localparam int ENTRY_W = $bits(gcrt_pkg::t_entry);
    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(DEPTH - 1);

    typedef enum logic [5:0] {
        S_CLEAR    = 6'b000001,
        S_IDLE     = 6'b000010,
        S_REQ_RD   = 6'b000100,
        S_REQ_EVAL = 6'b001000,
        S_SWEEP    = 6'b010000,
        S_FIN      = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [ADDR_W-1:0]            r_idx, n_idx;
    logic                         r_issue, n_issue;
    logic                         r_chk, n_chk;
    logic [ADDR_W-1:0]            r_chk_idx, n_chk_idx;
    logic [ADDR_W-1:0]            r_here, n_here;
    logic                         r_here_ok, n_here_ok;
    logic [gcrt_pkg::ROBOT_W-1:0] r_robot, n_robot;
    logic                         r_granted, n_granted;
    logic [gcrt_pkg::COUNT_W-1:0] r_count, n_count;
    logic                         r_out_valid, n_out_valid;
    gcrt_pkg::t_out               r_out, n_out;

    logic [HW-1:0]      w_here_wide;
    logic               w_here_ok;
    logic               w_robot_ok;
    logic               w_accept;
    logic               w_slot_free;

    logic               w_we;
    logic [ADDR_W-1:0]  w_wr_addr;
    gcrt_pkg::t_entry   w_wr_entry;
    logic [ADDR_W-1:0]  w_rd_addr;
    logic [ENTRY_W-1:0] w_rd_data;
    gcrt_pkg::t_entry   w_rd_entry;
    logic [ADDR_W-1:0]  w_unit_idx;
    gcrt_pkg::t_unit_res w_unit;

    assign w_here_wide = HW'(i_in.cell_row) * HW'(GRID_COLS) + HW'(i_in.cell_col);
    assign w_here_ok   = (7'(i_in.cell_row) < 7'(GRID_ROWS))
                      && (7'(i_in.cell_col) < 7'(GRID_COLS));
    assign w_robot_ok  = 7'(i_in.robot_id) < 7'(MAX_ROBOTS);

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;

    assign w_rd_entry  = gcrt_pkg::t_entry'(w_rd_data);
    assign w_unit_idx  = (r_state == S_SWEEP) ? r_chk_idx : r_here;

    gcrt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (ENTRY_W'(w_wr_entry)),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    gcrt_unit #(
        .ADDR_W (ADDR_W)
    ) u_unit (
        .i_entry   (w_rd_entry),
        .i_robot   (r_robot),
        .i_idx     (w_unit_idx),
        .i_here    (r_here),
        .i_here_ok (r_here_ok),
        .o_res     (w_unit)
    );

    // Table port control
    always_comb begin
        w_we             = 1'b0;
        w_wr_addr        = r_here;
        w_wr_entry.held  = 1'b0;
        w_wr_entry.owner = '0;
        w_rd_addr        = r_here;
        unique case (r_state)
            S_CLEAR: begin
                w_we      = 1'b1;
                w_wr_addr = r_idx;
            end
            S_REQ_EVAL: begin
                w_we             = !w_rd_entry.held;
                w_wr_entry.held  = 1'b1;
                w_wr_entry.owner = r_robot;
            end
            S_SWEEP: begin
                w_rd_addr = r_idx;
                w_we      = r_chk && w_unit.release_it;
                w_wr_addr = r_chk_idx;
            end
            S_IDLE, S_REQ_RD, S_FIN: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_issue     = r_issue;
        n_chk       = r_chk;
        n_chk_idx   = r_chk_idx;
        n_here      = r_here;
        n_here_ok   = r_here_ok;
        n_robot     = r_robot;
        n_granted   = r_granted;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;

        unique case (r_state)
            S_CLEAR: begin
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_here    = w_here_wide[ADDR_W-1:0];
                    n_here_ok = w_here_ok;
                    n_robot   = i_in.robot_id;
                    n_granted = 1'b0;
                    n_count   = '0;
                    n_idx     = '0;
                    n_issue   = 1'b1;
                    n_chk     = 1'b0;
                    if (!w_robot_ok) begin
                        n_state = S_FIN;
                    end else if (i_in.operation == gcrt_pkg::OP_LOCATE) begin
                        n_state = S_SWEEP;
                    end else if (w_here_ok) begin
                        n_state = S_REQ_RD;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_REQ_RD: begin
                n_state = S_REQ_EVAL;
            end
            S_REQ_EVAL: begin
                // a free cell is taken now; otherwise granted only if already ours
                n_granted = !w_rd_entry.held || w_unit.mine;
                n_state   = S_FIN;
            end
            S_SWEEP: begin
                // read one entry ahead, judge the one that arrived
                n_chk     = r_issue;
                n_chk_idx = r_idx;
                if (r_issue) begin
                    if (r_idx == LAST_IDX) begin
                        n_issue = 1'b0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                if (r_chk && w_unit.release_it && (r_count != gcrt_pkg::COUNT_MAX)) begin
                    n_count = r_count + 1'b1;
                end
                if (r_chk && (r_chk_idx == LAST_IDX)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // hold until the output register drains
                if (w_slot_free) begin
                    n_out_valid          = 1'b1;
                    n_out.granted        = r_granted;
                    n_out.released_count = r_count;
                    n_idx                = '0;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_issue     <= 1'b0;
            r_chk       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_issue     <= n_issue;
            r_chk       <= n_chk;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_idx <= n_chk_idx;
        r_here    <= n_here;
        r_here_ok <= n_here_ok;
        r_robot   <= n_robot;
        r_granted <= n_granted;
        r_count   <= n_count;
        r_out     <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
